[hdl/smt_pkg.sv]
package smt_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int VAL_W  = 32;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STATUS = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]        total;
        logic signed [VAL_W-1:0] item_value;
        logic                    item_valid;
        logic                    overflow;
        logic                    last;
    } t_out;

    // One result from the sequencer, qualified by its strobe.
    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

    // Access to the entry memory for one cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

[hdl/sorted_multiset_table_top.sv]
// Sorted multiset table: holds up to DEPTH signed 32-bit values in ascending
// order in one on-chip memory, duplicates included.
// Input channel: an item (mode, value) is taken at a rising edge where start
// is high and busy is low. Mode insert adds the value after any equal
// entries, mode delete removes every entry equal to the value, mode report
// lists each distinct value in ascending order, and mode status
// simply reports the count.
// Output channel: each result sits on o_result for exactly one cycle with
// o_valid high. Insert, delete and status give one result; report gives one
// result per distinct value, or a single empty result when the table is empty.
// The final result of every item has last set.
// Sequencing: an item with no memory read goes straight to the output
// register; an insert reads down through the entries that it moves up, and
// a delete or a report reads every held entry, all through the memory's
// single read port, one entry per cycle. busy drops in the cycle that shows
// the item's last result, so the next item can be taken then.
// Reset clears the entry count, so the table is empty; memory contents are
// left as they are and are never read before being written. The receiver
// cannot stall: every result must be taken in the cycle it is shown.
module sorted_multiset_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  smt_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_valid,
    output smt_pkg::t_out o_result
);
    import smt_pkg::*;

    t_ram_req         s_ram;
    logic [VAL_W-1:0] s_rdata;
    t_res             s_res;

    logic r_valid;
    t_out r_result;

    // Sequencer: walks the sorted entries for items that need them and keeps the count.
    smt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_ram   (s_ram),
        .i_rdata (s_rdata),
        .o_res   (s_res)
    );

    // Entry store: one write and one registered read per cycle.
    smt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram.we),
        .i_waddr (s_ram.waddr),
        .i_wdata (s_ram.wdata),
        .i_raddr (s_ram.raddr),
        .o_rdata (s_rdata)
    );

    // Output register: results leave from a flop, in the cycle after they are made.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= s_res.data;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hdl/smt_ram.sv]
module smt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/smt_ctrl.sv]
module smt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  smt_pkg::t_in              i_item,
    output logic                      busy,
    output smt_pkg::t_ram_req         o_ram,
    input  logic [smt_pkg::VAL_W-1:0] i_rdata,
    output smt_pkg::t_res             o_res
);
    import smt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_INS  = 5'b00010,
        ST_PUT  = 5'b00100,
        ST_DEL  = 5'b01000,
        ST_REP  = 5'b10000
    } t_state;

    // ST_REP is followed by one cycle that flushes the last distinct value;
    // a flag marks it so the state vector stays small.
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_held, n_held;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_wr, n_wr;
    logic                    r_flush, n_flush;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_prev, n_prev;

    logic signed [VAL_W-1:0] s_q;
    logic [CNT_W-1:0]        s_dec1;
    logic [CNT_W-1:0]        s_dec2;
    logic [CNT_W-1:0]        s_keep;

    assign s_q    = $signed(i_rdata);
    assign s_dec1 = r_idx - CNT_W'(1);
    assign s_dec2 = r_idx - CNT_W'(2);
    assign s_keep = r_wr + CNT_W'(s_q != r_val);
    assign busy   = (r_state != ST_IDLE) || r_flush;

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_idx   = r_idx;
        n_wr    = r_wr;
        n_flush = 1'b0;
        n_val   = r_val;
        n_prev  = r_prev;
        o_ram   = '0;
        o_res   = '0;

        if (r_flush) begin
            o_res.valid           = 1'b1;
            o_res.data.total      = r_held;
            o_res.data.item_value = r_prev;
            o_res.data.item_valid = 1'b1;
            o_res.data.last       = 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        n_val = i_item.value;
                        case (i_item.mode)
                            MODE_INSERT: begin
                                if (r_held >= CNT_W'(DEPTH)) begin
                                    o_res.valid         = 1'b1;
                                    o_res.data.total    = r_held;
                                    o_res.data.overflow = 1'b1;
                                    o_res.data.last     = 1'b1;
                                end else if (r_held == '0) begin
                                    o_ram.we         = 1'b1;
                                    o_ram.waddr      = '0;
                                    o_ram.wdata      = i_item.value;
                                    n_held           = CNT_W'(1);
                                    o_res.valid      = 1'b1;
                                    o_res.data.total = CNT_W'(1);
                                    o_res.data.last  = 1'b1;
                                end else begin
                                    // Walk down from the top, moving larger entries up one.
                                    n_idx       = r_held;
                                    o_ram.raddr = ADDR_W'(r_held - CNT_W'(1));
                                    n_state     = ST_INS;
                                end
                            end
                            MODE_DELETE: begin
                                if (r_held == '0) begin
                                    o_res.valid     = 1'b1;
                                    o_res.data.last = 1'b1;
                                end else begin
                                    o_ram.raddr = '0;
                                    n_idx       = CNT_W'(1);
                                    n_wr        = '0;
                                    n_state     = ST_DEL;
                                end
                            end
                            MODE_REPORT: begin
                                if (r_held == '0) begin
                                    o_res.valid     = 1'b1;
                                    o_res.data.last = 1'b1;
                                end else begin
                                    o_ram.raddr = '0;
                                    n_idx       = CNT_W'(1);
                                    n_state     = ST_REP;
                                end
                            end
                            default: begin
                                o_res.valid      = 1'b1;
                                o_res.data.total = r_held;
                                o_res.data.last  = 1'b1;
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    // s_q holds the entry just below write position r_idx.
                    if (s_q > r_val) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = ADDR_W'(r_idx);
                        o_ram.wdata = s_q;
                        n_idx       = s_dec1;
                        if (r_idx == CNT_W'(1)) begin
                            n_state = ST_PUT;
                        end else begin
                            o_ram.raddr = ADDR_W'(s_dec2);
                        end
                    end else begin
                        o_ram.we         = 1'b1;
                        o_ram.waddr      = ADDR_W'(r_idx);
                        o_ram.wdata      = r_val;
                        n_held           = r_held + CNT_W'(1);
                        o_res.valid      = 1'b1;
                        o_res.data.total = r_held + CNT_W'(1);
                        o_res.data.last  = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
                ST_PUT: begin
                    o_ram.we         = 1'b1;
                    o_ram.waddr      = ADDR_W'(r_idx);
                    o_ram.wdata      = r_val;
                    n_held           = r_held + CNT_W'(1);
                    o_res.valid      = 1'b1;
                    o_res.data.total = r_held + CNT_W'(1);
                    o_res.data.last  = 1'b1;
                    n_state          = ST_IDLE;
                end
                ST_DEL: begin
                    // Compact in place; the write index never passes the read index.
                    if (s_q != r_val) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = ADDR_W'(r_wr);
                        o_ram.wdata = s_q;
                    end
                    n_wr = s_keep;
                    if (r_idx < r_held) begin
                        o_ram.raddr = ADDR_W'(r_idx);
                        n_idx       = r_idx + CNT_W'(1);
                    end else begin
                        n_held           = s_keep;
                        o_res.valid      = 1'b1;
                        o_res.data.total = s_keep;
                        o_res.data.last  = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
                ST_REP: begin
                    // A value is reported once the next entry shows it is the last copy.
                    if ((r_idx != CNT_W'(1)) && (s_q != r_prev)) begin
                        o_res.valid           = 1'b1;
                        o_res.data.total      = r_held;
                        o_res.data.item_value = r_prev;
                        o_res.data.item_valid = 1'b1;
                    end
                    n_prev = s_q;
                    if (r_idx < r_held) begin
                        o_ram.raddr = ADDR_W'(r_idx);
                        n_idx       = r_idx + CNT_W'(1);
                    end else begin
                        n_flush = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_val  <= n_val;
        r_prev <= n_prev;
    end

endmodule

[tb/tb_sorted_multiset_table_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the sorted multiset table.
// A shadow copy of the table is kept here. Each accepted item is applied to it,
// and the results that the item must produce are queued. Every strobed result
// from the block is then compared, field by field, with the oldest queued one.
module tb_sorted_multiset_table_top;
    import smt_pkg::*;

    localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam int                      N_RANDOM  = 158;
    // The longest quiet stretch is an insert that moves every entry or a delete
    // on a full table. The watchdog limit is well above it.
    localparam int                      STALL_MAX = 3000;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_item  = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_result;

    sorted_multiset_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One row of the directed part. When typed is set, want is the result
    // written out by hand; otherwise the shadow table supplies the results.
    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_step;

    // Shadow of the block's state: the sorted cells and the count of entries.
    logic signed [VAL_W-1:0] shadow_cells [DEPTH];
    int                      shadow_count = 0;

    // Results that the block still owes, oldest first.
    t_out due_results [$];

    int  mismatch_count = 0;
    int  idle_pct       = 0;
    int  stall_cycles   = 0;
    bit  filling        = 1'b1;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Applies one item to the shadow table. When keep is set, the results that
    // the item causes are queued as due.
    task automatic shadow_apply(input t_in it, input bit keep);
        t_out res [$];
        int   i;
        case (it.mode)
            MODE_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    // A full table drops the value and raises overflow.
                    res.push_back('{total: CNT_W'(shadow_count), item_value: '0,
                                    item_valid: 1'b0, overflow: 1'b1, last: 1'b1});
                end else begin
                    // Equal values stay ahead of the new copy, so only strictly
                    // greater entries move up one cell.
                    i = shadow_count;
                    while (i > 0 && shadow_cells[i-1] > it.value) begin
                        shadow_cells[i] = shadow_cells[i-1];
                        i--;
                    end
                    shadow_cells[i] = it.value;
                    shadow_count++;
                    res.push_back('{total: CNT_W'(shadow_count), item_value: '0,
                                    item_valid: 1'b0, overflow: 1'b0, last: 1'b1});
                end
            end
            MODE_DELETE: begin
                int kept;
                kept = 0;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_cells[i] != it.value) begin
                        shadow_cells[kept] = shadow_cells[i];
                        kept++;
                    end
                end
                shadow_count = kept;
                res.push_back('{total: CNT_W'(shadow_count), item_value: '0,
                                item_valid: 1'b0, overflow: 1'b0, last: 1'b1});
            end
            MODE_REPORT: begin
                if (shadow_count == 0) begin
                    res.push_back('{total: '0, item_value: '0, item_valid: 1'b0,
                                    overflow: 1'b0, last: 1'b1});
                end else begin
                    // Only the final copy of each run of equal values is listed.
                    for (i = 0; i < shadow_count; i++) begin
                        if (i + 1 < shadow_count && shadow_cells[i+1] == shadow_cells[i]) begin
                            continue;
                        end
                        res.push_back('{total: CNT_W'(shadow_count),
                                        item_value: shadow_cells[i], item_valid: 1'b1,
                                        overflow: 1'b0, last: (i + 1 == shadow_count)});
                    end
                end
            end
            default: begin
                // The spare mode only reports the count.
                res.push_back('{total: CNT_W'(shadow_count), item_value: '0,
                                item_valid: 1'b0, overflow: 1'b0, last: 1'b1});
            end
        endcase
        if (keep) begin
            foreach (res[k]) due_results.push_back(res[k]);
        end
    endtask

    // Presents one item and holds it until the block takes it. Idle cycles
    // before the item are drawn one at a time, so gaps have random length.
    // The shadow table is updated at the edge where the item is taken.
    task automatic send_item(input t_in it, input bit typed, input t_out want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        shadow_apply(it, !typed);
        if (typed) due_results.push_back(want);
    endtask

    function automatic t_step mk_step(input logic [MODE_W-1:0] m,
                                      input logic signed [VAL_W-1:0] v,
                                      input bit typed, input int tot);
        t_step s;
        s.item  = '{mode: m, value: v};
        s.typed = typed;
        s.want  = '{total: CNT_W'(tot), item_value: '0, item_valid: 1'b0,
                    overflow: 1'b0, last: 1'b1};
        return s;
    endfunction

    // Random operand. Nearly half the values come from a small pool so that
    // duplicates are common; others are extremes, 0 or -1, or any 32-bit value.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            return VAL_W'($signed($urandom_range(7)) - 3);
        end else if (r < 60) begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    // Result checker. Results are sampled at the edge that ends their cycle.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result total=%0d value=%0d last=%b",
                                          o_result.total, o_result.item_value,
                                          o_result.last));
            end else begin
                want = due_results.pop_front();
                if (o_result.total !== want.total)
                    report_mismatch($sformatf("total %0d, expected %0d",
                                              o_result.total, want.total));
                if (o_result.item_value !== want.item_value)
                    report_mismatch($sformatf("item_value %0d, expected %0d",
                                              o_result.item_value, want.item_value));
                if (o_result.item_valid !== want.item_valid)
                    report_mismatch($sformatf("item_valid %b, expected %b",
                                              o_result.item_valid, want.item_valid));
                if (o_result.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              o_result.overflow, want.overflow));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_result.last, want.last));
            end
        end
    end

    // Watchdog: any accepted item or result restarts the count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_MAX) begin
                $display("[sorted_multiset_table_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_step steps [$];
        t_in   it;
        int    r;

        // The directed part: empty-table cases first, then the extremes and
        // duplicates of zero, then deletes that empty the table again.
        steps.push_back(mk_step(MODE_REPORT, 32'sd0,     1, 0));
        steps.push_back(mk_step(MODE_DELETE, 32'sd5,     1, 0));
        steps.push_back(mk_step(MODE_STATUS, VAL_MAX,    1, 0));
        steps.push_back(mk_step(MODE_INSERT, VAL_MAX,    1, 1));
        steps.push_back(mk_step(MODE_INSERT, VAL_MIN,    1, 2));
        steps.push_back(mk_step(MODE_INSERT, 32'sd0,     1, 3));
        steps.push_back(mk_step(MODE_INSERT, -32'sd1,    1, 4));
        steps.push_back(mk_step(MODE_INSERT, 32'sd0,     1, 5));
        steps.push_back(mk_step(MODE_INSERT, 32'sd0,     1, 6));
        steps.push_back(mk_step(MODE_INSERT, 32'sd1,     1, 7));
        steps.push_back(mk_step(MODE_REPORT, VAL_MIN,    0, 0));
        steps.push_back(mk_step(MODE_DELETE, 32'sd0,     0, 0));
        steps.push_back(mk_step(MODE_DELETE, 32'sd12345, 0, 0));
        steps.push_back(mk_step(MODE_STATUS, 32'sd0,     0, 0));
        steps.push_back(mk_step(MODE_INSERT, VAL_MIN,    0, 0));
        steps.push_back(mk_step(MODE_REPORT, -32'sd1,    0, 0));
        steps.push_back(mk_step(MODE_DELETE, VAL_MIN,    0, 0));
        steps.push_back(mk_step(MODE_DELETE, VAL_MAX,    0, 0));
        steps.push_back(mk_step(MODE_REPORT, 32'sd0,     0, 0));
        steps.push_back(mk_step(MODE_DELETE, -32'sd1,    0, 0));
        steps.push_back(mk_step(MODE_DELETE, 32'sd1,     0, 0));
        steps.push_back(mk_step(MODE_REPORT, VAL_MAX,    1, 0));

        // Synchronous reset, applied once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 27;
        foreach (steps[s]) send_item(steps[s].item, steps[s].typed, steps[s].want);

        // The random part runs in fill and drain sweeps. A fill sweep is mostly
        // inserts, so the table reaches DEPTH and overflow is usually exercised
        // before the sweep turns. A drain sweep deletes stored values until fewer
        // than eight entries remain. The sender's idle rate moves from 27 to 71
        // percent and then to none over the three thirds of the run.
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_pct = (n < N_RANDOM / 3) ? 27 : (n < 2 * N_RANDOM / 3) ? 71 : 0;
            if (filling && shadow_count == DEPTH && $urandom_range(99) < 30) begin
                filling = 1'b0;
            end else if (!filling && shadow_count < 8) begin
                filling = 1'b1;
            end
            it.value = pick_value();
            r = $urandom_range(99);
            if (filling) begin
                it.mode = (r < 85) ? MODE_INSERT : (r < 90) ? MODE_DELETE :
                          (r < 97) ? MODE_REPORT : MODE_STATUS;
            end else begin
                it.mode = (r < 55) ? MODE_DELETE : (r < 75) ? MODE_INSERT :
                          (r < 93) ? MODE_REPORT : MODE_STATUS;
                // Drain deletes mostly name a value that is really stored.
                if (it.mode == MODE_DELETE && shadow_count > 0 && $urandom_range(9) < 8) begin
                    it.value = shadow_cells[$urandom_range(shadow_count - 1)];
                end
            end
            if (it.mode == MODE_REPORT || it.mode == MODE_STATUS) begin
                it.value = $urandom();
            end
            send_item(it, 1'b0, '0);
        end
        start <= 1'b0;

        // Wait for every due result, then allow about one report's length
        // for anything stray to show up.
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[sorted_multiset_table_top] OK");
        end else begin
            $display("[sorted_multiset_table_top] ERROR");
        end
        $finish;
    end

endmodule
